[design/dma_remap_table_engine_macros.svh]
// Assertion macros for the remap table engine.
`ifndef DMA_REMAP_TABLE_ENGINE_MACROS_SVH
`define DMA_REMAP_TABLE_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DMART_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dmart assertion failed");
`define DMART_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dmart assertion failed");
`else
`define DMART_ASSERT_IMP(lbl, a, b)
`define DMART_ASSERT_NXT(lbl, a, b)
`endif
`endif

[design/dmart_pkg.sv]
`timescale 1ns / 1ps
package dmart_pkg;

  localparam int ATTACH_ENTRIES_DEF = 32;
  localparam int MAP_ENTRIES_DEF    = 64;
  localparam int PAGE_SHIFT_DEF     = 12;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_ATTACH    = 3'd1;
  localparam logic [2:0] OP_DETACH    = 3'd2;
  localparam logic [2:0] OP_MAP       = 3'd3;
  localparam logic [2:0] OP_UNMAP     = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_DISABLED     = 3'd2;
  localparam logic [2:0] ST_NOT_ATTACHED = 3'd3;
  localparam logic [2:0] ST_UNMAPPED     = 3'd4;
  localparam logic [2:0] ST_DENIED       = 3'd5;
  localparam logic [2:0] ST_REJECTED     = 3'd6;
  localparam logic [2:0] ST_FULL         = 3'd7;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_TIME   = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] pci_segment;
    logic [7:0]  pci_bus;
    logic [4:0]  pci_device;
    logic [2:0]  pci_function;
    logic [31:0] domain_id;
    logic [63:0] io_address;
    logic [63:0] span_bytes;
    logic [63:0] target_address;
    logic [1:0]  access_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] physical_address;
    logic [63:0] fault_sequence;
    logic [63:0] fault_time;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] dom;
    logic [63:0] addr;
    logic [63:0] last;
    logic [63:0] tgt;
    logic [1:0]  acc;
    logic        bad;
  } qitem_t;

  typedef struct packed {
    logic enable;
    logic [63:0] vtime;
  } cfg_t;

endpackage

[design/dma_remap_table_engine.sv]
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start / busy              item   (in_item_t)
// response  done, one-cycle strobe    result (out_item_t)
// config    cfg_write                 cfg_index, cfg_data
//
// Each item passes through the table unit in order: dequeue, parallel compare
// over all attach and map entries, priority select with the translation
// memory read, then resolve, update and register the result.
// A two-entry queue sits ahead of it; busy is high while the queue is full.
// rst is synchronous, clears the queue and valid bits and sets the fault counter to one.
// The receiver cannot stall; done pulses once for every item.
module dma_remap_table_engine #(
  parameter int ATTACH_ENTRIES = dmart_pkg::ATTACH_ENTRIES_DEF,
  parameter int MAP_ENTRIES    = dmart_pkg::MAP_ENTRIES_DEF,
  parameter int PAGE_SHIFT     = dmart_pkg::PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dmart_pkg::in_item_t  item,
  output logic                done,
  output dmart_pkg::out_item_t result,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);
  import dmart_pkg::*;
`include "dma_remap_table_engine_macros.svh"

  qitem_t fq;
  qitem_t head;
  cfg_t   cfg;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  assign busy = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.vtime  <= 64'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLE: cfg.enable <= cfg_data[0];
        CFG_TIME:   cfg.vtime  <= cfg_data;
        default:    cfg.enable <= cfg.enable;
      endcase
    end
  end

  dmart_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .start(start),
    .full (q_full),
    .item (item),
    .push (push),
    .qitem(fq)
  );

  dmart_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (fq),
    .pop  (pop),
    .dout (head),
    .empty(q_empty),
    .full (q_full)
  );

  dmart_back #(
    .ATTACH_ENTRIES(ATTACH_ENTRIES),
    .MAP_ENTRIES   (MAP_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .cfg   (cfg),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

  `DMART_ASSERT_NXT(a_done_single, done, !done)
  `DMART_ASSERT_NXT(a_push_lands, start && !busy, !q_empty)
  `DMART_ASSERT_IMP(a_phys_only_ok, done && (result.status != ST_OK),
                    result.physical_address == 64'd0)
  `DMART_ASSERT_IMP(a_seq_only_fault, done && (result.status == ST_OK),
                    result.fault_sequence == 64'd0)

endmodule

[design/dmart_front.sv]
`timescale 1ns / 1ps
module dmart_front #(
  parameter int PAGE_SHIFT = dmart_pkg::PAGE_SHIFT_DEF
) (
  input  logic              start,
  input  logic              full,
  input  dmart_pkg::in_item_t item,
  output logic              push,
  output dmart_pkg::qitem_t  qitem
);
  import dmart_pkg::*;

  localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;

  logic [64:0] sum_a;
  logic [64:0] sum_t;
  logic        rok_a;
  logic        rok_t;
  logic        pok_a;
  logic        pok_t;
  logic        acc_zero;

  assign push = start && !full;

  always_comb begin
    sum_a    = {1'b0, item.io_address} + {1'b0, item.span_bytes} - 65'd1;
    sum_t    = {1'b0, item.target_address} + {1'b0, item.span_bytes} - 65'd1;
    rok_a    = (item.span_bytes != 64'd0) && !sum_a[64];
    rok_t    = (item.span_bytes != 64'd0) && !sum_t[64];
    pok_a    = rok_a && ((item.io_address & PMASK) == 64'd0)
               && ((item.span_bytes & PMASK) == 64'd0);
    pok_t    = rok_t && ((item.target_address & PMASK) == 64'd0);
    acc_zero = (item.access_bits == 2'd0);
    qitem.op   = item.opcode;
    qitem.key  = {item.pci_segment, item.pci_bus, item.pci_device, item.pci_function};
    qitem.dom  = item.domain_id;
    qitem.addr = item.io_address;
    qitem.last = sum_a[63:0];
    qitem.tgt  = item.target_address;
    qitem.acc  = item.access_bits;
    case (item.opcode)
      OP_TRANSLATE: qitem.bad = !rok_a || acc_zero;
      OP_ATTACH:    qitem.bad = 1'b0;
      OP_DETACH:    qitem.bad = 1'b0;
      OP_MAP:       qitem.bad = !pok_a || !pok_t || acc_zero;
      OP_UNMAP:     qitem.bad = !pok_a;
      default:      qitem.bad = 1'b1;
    endcase
  end

endmodule

[design/dmart_queue.sv]
`timescale 1ns / 1ps
module dmart_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dmart_pkg::qitem_t din,
  input  logic             pop,
  output dmart_pkg::qitem_t dout,
  output logic             empty,
  output logic             full
);
  import dmart_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qitem_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(QUEUE_DEPTH));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

[design/dmart_back.sv]
`timescale 1ns / 1ps
module dmart_back #(
  parameter int ATTACH_ENTRIES = dmart_pkg::ATTACH_ENTRIES_DEF,
  parameter int MAP_ENTRIES    = dmart_pkg::MAP_ENTRIES_DEF,
  parameter int PAGE_SHIFT     = dmart_pkg::PAGE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  dmart_pkg::qitem_t   head,
  input  dmart_pkg::cfg_t     cfg,
  output logic               pop,
  output logic               done,
  output dmart_pkg::out_item_t result
);
  import dmart_pkg::*;

  localparam int AN = ATTACH_ENTRIES;
  localparam int MN = MAP_ENTRIES;
  localparam int AW = (AN > 1) ? $clog2(AN) : 1;
  localparam int MW = (MN > 1) ? $clog2(MN) : 1;
  localparam int PG = 64 - PAGE_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SEL, S_OUT} state_t;

  typedef struct packed {
    logic [PG-1:0] delta;
    logic [1:0]    acc;
  } xlat_t;

  state_t state;
  qitem_t cur;

  logic [AN-1:0] att_valid;
  logic [31:0]   att_key [AN];
  logic [31:0]   att_dom [AN];
  logic [MN-1:0] map_valid;
  logic [31:0]   map_dom [MN];
  logic [PG-1:0] map_first [MN];
  logic [PG-1:0] map_end [MN];
  xlat_t         xlat_mem [MN];
  xlat_t         xlat_rd;

  logic [AN-1:0] v_ahit, v_adok, v_afree;
  logic [MN-1:0] v_cov, v_ovl, v_exact, v_mfree;
  logic [AN-1:0] c_ahit, c_adok, c_afree;
  logic [MN-1:0] c_cov, c_ovl, c_exact, c_mfree;

  logic [AW-1:0] e_ahit, e_afree;
  logic [MW-1:0] e_cov, e_exact, e_mfree;
  logic [AW-1:0] ahit_idx, afree_idx;
  logic [MW-1:0] exact_idx, mfree_idx;
  logic          ahit_any, adok_any, afree_any;
  logic          cov_any, ovl_any, exact_any, mfree_any;

  logic [PG-1:0] apage, lpage;
  logic [63:0]   fault_num;
  logic [2:0]    st;
  logic [63:0]   phys;

  assign pop   = (state == S_IDLE) && !empty;
  assign apage = cur.addr[63:PAGE_SHIFT];
  assign lpage = cur.last[63:PAGE_SHIFT];

  always_comb begin
    for (int i = 0; i < AN; i++) begin
      c_ahit[i]  = att_valid[i] && (att_key[i] == cur.key);
      c_adok[i]  = c_ahit[i] && (att_dom[i] == cur.dom);
      c_afree[i] = !att_valid[i];
    end
    for (int i = 0; i < MN; i++) begin
      c_cov[i]   = map_valid[i] && (map_dom[i] == cur.dom)
                   && (apage >= map_first[i]) && (lpage <= map_end[i]);
      c_ovl[i]   = map_valid[i] && (map_dom[i] == cur.dom)
                   && (apage <= map_end[i]) && (map_first[i] <= lpage);
      c_exact[i] = map_valid[i] && (map_dom[i] == cur.dom)
                   && (apage == map_first[i]) && (lpage == map_end[i]);
      c_mfree[i] = !map_valid[i];
    end
  end

  always_comb begin
    e_ahit  = '0;
    e_afree = '0;
    e_cov   = '0;
    e_exact = '0;
    e_mfree = '0;
    for (int i = AN - 1; i >= 0; i--) begin
      if (v_ahit[i]) begin
        e_ahit = AW'(i);
      end
      if (v_afree[i]) begin
        e_afree = AW'(i);
      end
    end
    for (int i = MN - 1; i >= 0; i--) begin
      if (v_cov[i]) begin
        e_cov = MW'(i);
      end
      if (v_exact[i]) begin
        e_exact = MW'(i);
      end
      if (v_mfree[i]) begin
        e_mfree = MW'(i);
      end
    end
  end

  always_comb begin
    phys = 64'd0;
    case (cur.op)
      OP_TRANSLATE: begin
        if (cur.bad) begin
          st = ST_INVALID;
        end else if (!cfg.enable) begin
          st = ST_DISABLED;
        end else if (!adok_any) begin
          st = ST_NOT_ATTACHED;
        end else if (!cov_any) begin
          st = ST_UNMAPPED;
        end else if ((cur.acc & xlat_rd.acc) != cur.acc) begin
          st = ST_DENIED;
        end else begin
          st   = ST_OK;
          phys = {xlat_rd.delta, PAGE_SHIFT'(0)} + cur.addr;
        end
      end
      OP_ATTACH: begin
        if (ahit_any) begin
          st = adok_any ? ST_OK : ST_REJECTED;
        end else begin
          st = afree_any ? ST_OK : ST_FULL;
        end
      end
      OP_DETACH: st = ahit_any ? ST_OK : ST_REJECTED;
      OP_MAP: begin
        if (cur.bad) begin
          st = ST_INVALID;
        end else if (ovl_any) begin
          st = ST_REJECTED;
        end else begin
          st = mfree_any ? ST_OK : ST_FULL;
        end
      end
      OP_UNMAP: begin
        if (cur.bad) begin
          st = ST_INVALID;
        end else begin
          st = exact_any ? ST_OK : ST_REJECTED;
        end
      end
      default: st = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      att_valid <= '0;
      map_valid <= '0;
      fault_num <= 64'd1;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_SEL;
        S_SEL: state <= S_OUT;
        S_OUT: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if ((cur.op == OP_TRANSLATE) && (st != ST_OK)) begin
            fault_num <= fault_num + 64'd1;
          end
          if ((cur.op == OP_ATTACH) && !ahit_any && afree_any) begin
            att_valid[afree_idx] <= 1'b1;
          end
          if ((cur.op == OP_DETACH) && ahit_any) begin
            att_valid[ahit_idx] <= 1'b0;
          end
          if ((cur.op == OP_MAP) && (st == ST_OK)) begin
            map_valid[mfree_idx] <= 1'b1;
          end
          if ((cur.op == OP_UNMAP) && (st == ST_OK)) begin
            map_valid[exact_idx] <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_CMP) begin
      v_ahit  <= c_ahit;
      v_adok  <= c_adok;
      v_afree <= c_afree;
      v_cov   <= c_cov;
      v_ovl   <= c_ovl;
      v_exact <= c_exact;
      v_mfree <= c_mfree;
    end
    if (state == S_SEL) begin
      ahit_idx  <= e_ahit;
      afree_idx <= e_afree;
      exact_idx <= e_exact;
      mfree_idx <= e_mfree;
      ahit_any  <= |v_ahit;
      adok_any  <= |v_adok;
      afree_any <= |v_afree;
      cov_any   <= |v_cov;
      ovl_any   <= |v_ovl;
      exact_any <= |v_exact;
      mfree_any <= |v_mfree;
      xlat_rd   <= xlat_mem[e_cov];
    end
    if (state == S_OUT) begin
      result.status           <= st;
      result.physical_address <= phys;
      if ((cur.op == OP_TRANSLATE) && (st != ST_OK)) begin
        result.fault_sequence <= fault_num;
        result.fault_time     <= cfg.vtime;
      end else begin
        result.fault_sequence <= 64'd0;
        result.fault_time     <= 64'd0;
      end
      if ((cur.op == OP_ATTACH) && !ahit_any && afree_any) begin
        att_key[afree_idx] <= cur.key;
        att_dom[afree_idx] <= cur.dom;
      end
      if ((cur.op == OP_MAP) && (st == ST_OK)) begin
        map_dom[mfree_idx]        <= cur.dom;
        map_first[mfree_idx]      <= apage;
        map_end[mfree_idx]        <= lpage;
        xlat_mem[mfree_idx].delta <= cur.tgt[63:PAGE_SHIFT] - apage;
        xlat_mem[mfree_idx].acc   <= cur.acc;
      end
    end
  end

endmodule
